FILE: src/assert_macros.svh
// Assertion macros shared by the block's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a signal is never unknown out of reset.
`define ASSERT_KNOWN(label, clk, rst_n, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) else $error(msg);
`endif

FILE: src/aes_pkg.sv
// Types, constants and round functions for the AES-128 encrypt pipeline.
package aes_pkg;

    localparam int NumRounds = 10;
    localparam logic [7:0] GfReduce = 8'h1b;
    localparam logic [7:0] RconInit = 8'h01;
    localparam logic [3:0] RegKeyHigh = 4'd0;
    localparam logic [3:0] RegKeyLow = 4'd1;
    localparam int CfgIndexWidth = 4;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } plain_word_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } cipher_word_t;

    // Data handed from one round cell to the next.
    typedef struct packed {
        logic         valid;
        logic [127:0] state;
        logic [127:0] rkey;
        logic [7:0]   rcon;
    } round_word_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Byte i of a 128-bit word, byte 0 in the top bits.
    function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
        return w[127 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GfReduce : 8'h00);
    endfunction

endpackage

FILE: src/aes_round_cell.sv
// One AES round: key add, substitution, row shift, optional column mix, key step.
module aes_round_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 last,
    input  aes_pkg::round_word_t din,
    output aes_pkg::round_word_t dout
);
    import aes_pkg::*;

    logic [127:0] sub_shift;
    logic [127:0] mixed;
    logic [127:0] rkey_next;
    logic         valid_reg;
    logic [127:0] state_reg;
    logic [127:0] rkey_reg;
    logic [7:0]   rcon_reg;

    // Add key, substitute and shift rows
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sub_shift[127 - 8 * (4 * c + r) -: 8] =
                    SBOX[get_byte(din.state, 4 * ((c + r) % 4) + r)
                         ^ get_byte(din.rkey, 4 * ((c + r) % 4) + r)];
            end
        end
    end

    // Mix columns, skipped in the last round
    always_comb
    begin
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(sub_shift, 4 * c);
            a1 = get_byte(sub_shift, 4 * c + 1);
            a2 = get_byte(sub_shift, 4 * c + 2);
            a3 = get_byte(sub_shift, 4 * c + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            mixed[127 - 32 * c -: 32] = {a0 ^ all ^ gf_double(a0 ^ a1),
                                         a1 ^ all ^ gf_double(a1 ^ a2),
                                         a2 ^ all ^ gf_double(a2 ^ a3),
                                         a3 ^ all ^ gf_double(a3 ^ a0)};
        end
    end

    // Advance the round key
    always_comb
    begin
        logic [31:0] w0, w1, w2, w3;
        w3 = din.rkey[31:0];
        w0 = din.rkey[127:96] ^ {SBOX[w3[23:16]] ^ din.rcon, SBOX[w3[15:8]],
                                 SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w1 = din.rkey[95:64] ^ w0;
        w2 = din.rkey[63:32] ^ w1;
        rkey_next = {w0, w1, w2, w2 ^ w3};
    end

    // Hold valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= din.valid;
        end
    end

    // Register the payload
    always_ff @(posedge clk)
    begin
        state_reg <= last ? sub_shift : mixed;
        rkey_reg  <= rkey_next;
        rcon_reg  <= gf_double(din.rcon);
    end

    assign dout = '{valid: valid_reg, state: state_reg, rkey: rkey_reg, rcon: rcon_reg};
endmodule

FILE: src/aes128_block_encrypt.sv
// AES-128 encrypt: ten round cells in a chain, one block per cycle.
// Ten round-cell registers and one output register lie between start and done.
// Throughput: one block every cycle; busy stays low, the chain never stalls.
// Reset clears the valid chain and both key registers to zero.
module aes128_block_encrypt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  aes_pkg::plain_word_t  plain,
    output logic                  done,
    output aes_pkg::cipher_word_t cipher,
    input  logic                  cfg_we,
    input  logic [aes_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [63:0]           cfg_data
);
    import aes_pkg::*;
    `include "assert_macros.svh"

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    round_word_t  chain [NumRounds + 1];
    logic         done_reg;
    cipher_word_t cipher_reg;

    assign busy = 1'b0;

    // Store key words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == RegKeyHigh)
            begin
                key_high_reg <= cfg_data;
            end
            else if (cfg_index == RegKeyLow)
            begin
                key_low_reg <= cfg_data;
            end
        end
    end

    assign chain[0] = '{valid: start, state: plain, rkey: {key_high_reg, key_low_reg},
                        rcon: RconInit};

    // Chain the round cells
    for (genvar g = 0; g < NumRounds; g++)
    begin : g_round
        aes_round_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .last (g == NumRounds - 1),
            .din  (chain[g]),
            .dout (chain[g + 1])
        );
    end

    // Add the final key and strobe the word out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain[NumRounds].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cipher_reg <= chain[NumRounds].state ^ chain[NumRounds].rkey;
    end

    assign done   = done_reg;
    assign cipher = cipher_reg;

    `ASSERT_IMPL(a_latency, clk, rst_n, start |-> ##11 done, "done missing 11 cycles after start")
    `ASSERT_IMPL(a_no_spurious, clk, rst_n, done |-> $past(start, 11), "done without a start")
    `ASSERT_KNOWN(a_done_known, clk, rst_n, done, "done unknown")
endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the AES-128 block encrypt pipeline.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    localparam int PipeLatency = 11;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // S-box, kept local so the predictor stands on its own.
    localparam logic [7:0] SUB_TBL [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5, 8'h30, 8'h01, 8'h67, 8'h2b,
        8'hfe, 8'hd7, 8'hab, 8'h76, 8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0, 8'hb7, 8'hfd, 8'h93, 8'h26,
        8'h36, 8'h3f, 8'hf7, 8'hcc, 8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a, 8'h07, 8'h12, 8'h80, 8'he2,
        8'heb, 8'h27, 8'hb2, 8'h75, 8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84, 8'h53, 8'hd1, 8'h00, 8'hed,
        8'h20, 8'hfc, 8'hb1, 8'h5b, 8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85, 8'h45, 8'hf9, 8'h02, 8'h7f,
        8'h50, 8'h3c, 8'h9f, 8'ha8, 8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2, 8'hcd, 8'h0c, 8'h13, 8'hec,
        8'h5f, 8'h97, 8'h44, 8'h17, 8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88, 8'h46, 8'hee, 8'hb8, 8'h14,
        8'hde, 8'h5e, 8'h0b, 8'hdb, 8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79, 8'he7, 8'hc8, 8'h37, 8'h6d,
        8'h8d, 8'hd5, 8'h4e, 8'ha9, 8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6, 8'he8, 8'hdd, 8'h74, 8'h1f,
        8'h4b, 8'hbd, 8'h8b, 8'h8a, 8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e, 8'he1, 8'hf8, 8'h98, 8'h11,
        8'h69, 8'hd9, 8'h8e, 8'h94, 8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2d, 8'h0f,
        8'hb0, 8'h54, 8'hbb, 8'h16
    };

    int err_count = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Holds the key and the queue of expected ciphertext words.
    class cipher_scoreboard;
        logic [127:0] key;
        cipher_word_t pending_q[$];

        function new();
            key = '0;
        endfunction

        function automatic logic [7:0] xtime(input logic [7:0] a);
            return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        endfunction

        function automatic cipher_word_t encrypt(input logic [127:0] blk);
            logic [7:0] st[16];
            logic [7:0] rk[16];
            logic [7:0] t[16];
            logic [7:0] rc;
            logic [7:0] a0, a1, a2, a3, all;
            logic [127:0] res;
            int src;
            rc = 8'h01;
            for (int i = 0; i < 16; i++)
            begin
                st[i] = blk[127 - 8 * i -: 8];
                rk[i] = key[127 - 8 * i -: 8];
            end
            for (int rnd = 1; rnd <= 10; rnd++)
            begin
                // add key, substitute and shift rows in one pass
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                    begin
                        src = 4 * ((c + r) % 4) + r;
                        t[4 * c + r] = SUB_TBL[st[src] ^ rk[src]];
                    end
                st = t;
                // advance the round key
                rk[0] ^= SUB_TBL[rk[13]] ^ rc;
                rk[1] ^= SUB_TBL[rk[14]];
                rk[2] ^= SUB_TBL[rk[15]];
                rk[3] ^= SUB_TBL[rk[12]];
                for (int i = 4; i < 16; i++)
                    rk[i] ^= rk[i - 4];
                rc = xtime(rc);
                if (rnd < 10)
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = st[4 * c]; a1 = st[4 * c + 1];
                        a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
                        all = a0 ^ a1 ^ a2 ^ a3;
                        st[4 * c] = a0 ^ all ^ xtime(a0 ^ a1);
                        st[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
                        st[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
                        st[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
                    end
            end
            for (int i = 0; i < 16; i++)
                res[127 - 8 * i -: 8] = st[i] ^ rk[i];
            return res;
        endfunction

        function void note_plain(input plain_word_t w);
            pending_q.push_back(encrypt(w));
        endfunction

        task check_cipher(input cipher_word_t w);
            cipher_word_t exp_w;
            if (pending_q.size() == 0)
            begin
                report_mismatch("unexpected word", w.cipher_high, '0);
                return;
            end
            exp_w = pending_q.pop_front();
            if (w.cipher_high !== exp_w.cipher_high)
                report_mismatch("cipher_high", w.cipher_high, exp_w.cipher_high);
            if (w.cipher_low !== exp_w.cipher_low)
                report_mismatch("cipher_low", w.cipher_low, exp_w.cipher_low);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    plain_word_t plain = '0;
    logic done;
    cipher_word_t cipher;
    logic cfg_we = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    cipher_scoreboard sb = new();
    idle_mode_t idle_mode = IDLE_NONE;

    aes128_block_encrypt u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .plain(plain),
        .done(done), .cipher(cipher), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Check every word the block hands out.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_cipher(cipher);
        else if (rst_n && done !== 1'b0)
            report_mismatch("done unknown", '0, '0);
    end

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        // indexes above the key registers are dropped by the block
        if (idx == RegKeyHigh)
            sb.key[127:64] = val;
        else if (idx == RegKeyLow)
            sb.key[63:0] = val;
    endtask

    // Let every outstanding word drain before a register write.
    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending_q.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (PipeLatency + 2) @(posedge clk);
    endtask

    // Present one word and hold it until accepted.
    task automatic send_plain(input plain_word_t w);
        if ((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
            $urandom_range(99) < 78)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 78);
        end
        start <= 1'b1;
        plain <= w;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        sb.note_plain(w);
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly random, sometimes sparse or dense bit patterns.
    function automatic logic [63:0] pattern64();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            3: return ~(64'd1 << $urandom_range(63));
            default: return rand64();
        endcase
    endfunction

    initial
    begin
        plain_word_t w;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // FIPS-197 vector, then more blocks under the same key
        write_reg(RegKeyHigh, 64'h0001020304050607);
        write_reg(RegKeyLow, 64'h08090a0b0c0d0e0f);
        send_plain({64'h0011223344556677, 64'h8899aabbccddeeff});
        send_plain('0);
        send_plain('1);
        send_plain({64'h8000000000000000, 64'h0000000000000001});
        stop_sending();
        drain();
        // out-of-range index must not touch the key
        write_reg(4'd2, '1);
        write_reg(4'd15, 64'hdeadbeefdeadbeef);
        send_plain({64'h0011223344556677, 64'h8899aabbccddeeff});
        stop_sending();
        drain();
        write_reg(RegKeyHigh, '0);
        write_reg(RegKeyLow, '0);
        send_plain('0);
        send_plain('1);
        stop_sending();
        drain();
        write_reg(RegKeyHigh, '1);
        write_reg(RegKeyLow, '1);
        send_plain('0);
        send_plain('1);
        send_plain({64'h5555555555555555, 64'haaaaaaaaaaaaaaaa});
        stop_sending();
        drain();

        // random phases, each rewriting the high key word and mostly the low one
        for (int ph = 0; ph < 12; ph++)
        begin
            idle_mode = idle_mode_t'(ph % 4);
            write_reg(RegKeyHigh, pattern64());
            if ($urandom_range(3) != 0)
                write_reg(RegKeyLow, pattern64());
            if ($urandom_range(3) == 0)
                write_reg(CfgIndexWidth'($urandom_range(15, 2)), rand64());
            for (int n = 0; n < 125; n++)
            begin
                w.plain_high = pattern64();
                w.plain_low = pattern64();
                send_plain(w);
            end
            stop_sending();
            drain();
        end

        if (sb.pending_q.size() != 0)
            report_mismatch("words left over", 64'(sb.pending_q.size()), '0);
        if (err_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule
